// File: src/brsp_pkg.sv
// ----------------------------------------------------------------------------
// brsp_pkg
// Shared types and constants of the base relocation stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package brsp_pkg;

    // Payload widths
    localparam int HALF_W   = 16;
    localparam int ADDR_W   = 64;
    localparam int WORD_W   = 32;
    localparam int OFFSET_W = 12;
    localparam int TYPE_W   = 4;
    localparam int REL_W    = WORD_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_BASE  = 1'd1;

    // Relocation entry types that produce a fixup
    localparam logic [TYPE_W-1:0] TYPE_HIGHLOW = 4'd3;
    localparam logic [TYPE_W-1:0] TYPE_DIR64   = 4'd10;

    // Block header length in bytes, and bytes per entry
    localparam logic [WORD_W-1:0] HDR_BYTES   = 32'd8;
    localparam logic [WORD_W-1:0] ENTRY_BYTES = 32'd2;

    // Default depth of the command queue
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Parse position within the directory
    typedef enum logic [2:0] {
        PH_PAGE_LO = 3'd0,
        PH_PAGE_HI = 3'd1,
        PH_SIZE_LO = 3'd2,
        PH_SIZE_HI = 3'd3,
        PH_ENTRY   = 3'd4
    } phase_t;

    // Command from the front end to the back end
    typedef struct packed {
        logic [REL_W-1:0] rel_addr;    // page + offset, not yet based
        logic             fixup_width; // 1: 64-bit word
        logic             status;      // 1: invalid block
    } cmd_t;

    // Push request into the queue
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

endpackage

`default_nettype wire

// File: src/brsp_front.sv
// ----------------------------------------------------------------------------
// brsp_front
// Header gathering, block validation and entry classification.
// ----------------------------------------------------------------------------
`default_nettype none

module brsp_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_fire,
    input  wire logic [brsp_pkg::HALF_W-1:0]   half_word,
    input  wire logic [brsp_pkg::WORD_W-1:0]   table_size,
    output brsp_pkg::push_t                    push
);

    brsp_pkg::phase_t phase_reg, phase_next;
    logic [brsp_pkg::WORD_W-1:0] page_reg, page_next;
    logic [brsp_pkg::HALF_W-1:0] size_lo_reg, size_lo_next;
    logic [brsp_pkg::WORD_W-1:0] left_reg, left_next;
    logic [brsp_pkg::WORD_W-1:0] used_reg, used_next;
    logic                        stopped_reg, stopped_next;

    logic [brsp_pkg::WORD_W-1:0]   full_size;
    logic [brsp_pkg::REL_W-1:0]    end_sum;
    logic                          bad_block;
    logic [brsp_pkg::WORD_W-1:0]   left_dec;
    logic [brsp_pkg::OFFSET_W-1:0] offset;
    logic [brsp_pkg::TYPE_W-1:0]   entry_type;

    // Header check: size below a header, odd, or past the end of the table
    assign full_size = {half_word, size_lo_reg};
    assign end_sum   = {1'b0, used_reg} + {1'b0, full_size};
    assign bad_block = (full_size < brsp_pkg::HDR_BYTES) || full_size[0]
                     || (end_sum > {1'b0, table_size});

    assign left_dec   = left_reg - brsp_pkg::ENTRY_BYTES;
    assign offset     = half_word[brsp_pkg::OFFSET_W-1:0];
    assign entry_type = half_word[brsp_pkg::HALF_W-1:brsp_pkg::OFFSET_W];

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= brsp_pkg::PH_PAGE_LO;
            page_reg    <= '0;
            size_lo_reg <= '0;
            left_reg    <= '0;
            used_reg    <= '0;
            stopped_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            page_reg    <= page_next;
            size_lo_reg <= size_lo_next;
            left_reg    <= left_next;
            used_reg    <= used_next;
            stopped_reg <= stopped_next;
        end
    end

    // Next state and queue push
    always_comb begin
        phase_next   = phase_reg;
        page_next    = page_reg;
        size_lo_next = size_lo_reg;
        left_next    = left_reg;
        used_next    = used_reg;
        stopped_next = stopped_reg;
        push         = '0;

        if (in_fire && !stopped_reg) begin
            case (phase_reg)
                brsp_pkg::PH_PAGE_HI: begin
                    page_next[brsp_pkg::WORD_W-1:brsp_pkg::HALF_W] = half_word;
                    phase_next = brsp_pkg::PH_SIZE_LO;
                end
                brsp_pkg::PH_SIZE_LO: begin
                    size_lo_next = half_word;
                    phase_next   = brsp_pkg::PH_SIZE_HI;
                end
                brsp_pkg::PH_SIZE_HI: begin
                    if (bad_block) begin
                        stopped_next   = 1'b1;
                        phase_next     = brsp_pkg::PH_PAGE_LO;
                        push.valid     = 1'b1;
                        push.cmd.status = 1'b1;
                    end else begin
                        used_next = end_sum[brsp_pkg::WORD_W-1:0];
                        left_next = full_size - brsp_pkg::HDR_BYTES;
                        phase_next = (full_size == brsp_pkg::HDR_BYTES) ?
                                     brsp_pkg::PH_PAGE_LO : brsp_pkg::PH_ENTRY;
                    end
                end
                brsp_pkg::PH_ENTRY: begin
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        phase_next = brsp_pkg::PH_PAGE_LO;
                    end
                    if (entry_type == brsp_pkg::TYPE_HIGHLOW ||
                        entry_type == brsp_pkg::TYPE_DIR64) begin
                        push.valid            = 1'b1;
                        push.cmd.rel_addr     = {1'b0, page_reg} +
                                                brsp_pkg::REL_W'(offset);
                        push.cmd.fixup_width  = (entry_type == brsp_pkg::TYPE_DIR64);
                    end
                end
                default: begin
                    // Start of a block, unless the table is used up
                    phase_next = brsp_pkg::PH_PAGE_LO;
                    if (used_reg < table_size) begin
                        page_next    = {{(brsp_pkg::WORD_W-brsp_pkg::HALF_W){1'b0}},
                                        half_word};
                        size_lo_next = '0;
                        left_next    = '0;
                        phase_next   = brsp_pkg::PH_PAGE_HI;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/brsp_queue.sv
// ----------------------------------------------------------------------------
// brsp_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module brsp_queue #(
    parameter int DEPTH = brsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire brsp_pkg::push_t push,
    input  wire logic            pop,
    output brsp_pkg::cmd_t       head,
    output logic                 empty,
    output logic                 full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    brsp_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/brsp_back.sv
// ----------------------------------------------------------------------------
// brsp_back
// Forms the absolute fixup address and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module brsp_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire brsp_pkg::cmd_t                head,
    input  wire logic                          empty,
    output logic                               pop,
    input  wire logic [brsp_pkg::ADDR_W-1:0]   load_base,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [brsp_pkg::ADDR_W-1:0]        m_target_address,
    output logic                               m_fixup_width,
    output logic                               m_status
);

    logic                        valid_reg;
    logic [brsp_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                        width_reg;
    logic                        status_reg;

    // Take the next command when the output register is free or draining
    assign pop = !empty && (!valid_reg || m_ready);

    // Error results carry a zero address
    assign addr_next = head.status ? '0 :
                       load_base + brsp_pkg::ADDR_W'(head.rel_addr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            addr_reg   <= addr_next;
            width_reg  <= head.fixup_width;
            status_reg <= head.status;
        end
    end

    assign m_valid          = valid_reg;
    assign m_target_address = addr_reg;
    assign m_fixup_width    = width_reg;
    assign m_status         = status_reg;

endmodule

`default_nettype wire

// File: src/base_relocation_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// base_relocation_stream_parser_unit
// Parses a base relocation directory streamed as 16-bit halfwords and
// issues one fixup request per type 3 or type 10 entry.
// ----------------------------------------------------------------------------
// The unit takes one halfword per clock and keeps that rate as long as the
// consumer takes results at least as fast as fixup entries occur. A result
// reaches the output register by way of the command queue: the front-end
// parser classifies the halfword in the cycle it is offered and writes the
// command queue at the accepting edge; from the queue the command passes
// through the 64-bit base add into the output register, where the consumer
// takes it. When the consumer stalls, the queue of QUEUE_DEPTH commands plus
// the output register absorb results, and s_ready drops once the queue is
// full. The first invalid block header yields a single request with m_status
// set and address zero; the rest of the stream is then accepted and dropped
// until reset. The user must write table_size and load_base through the cfg
// port only while no request is in flight; the unit does not enforce this.
`default_nettype none

module base_relocation_stream_parser_unit #(
    parameter int QUEUE_DEPTH = brsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [brsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [brsp_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // halfword stream
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [brsp_pkg::HALF_W-1:0]       s_half_word,
    // fixup requests
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [brsp_pkg::ADDR_W-1:0]            m_target_address,
    output logic                                   m_fixup_width,
    output logic                                   m_status
);

    logic [brsp_pkg::WORD_W-1:0] table_size_reg;
    logic [brsp_pkg::ADDR_W-1:0] load_base_reg;

    logic            in_fire;
    brsp_pkg::push_t push;
    brsp_pkg::cmd_t  head;
    logic            q_empty, q_full, q_pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= '0;
            load_base_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                brsp_pkg::REG_TABLE_SIZE: table_size_reg <= cfg_wr_data[brsp_pkg::WORD_W-1:0];
                brsp_pkg::REG_LOAD_BASE:  load_base_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    brsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .half_word  (s_half_word),
        .table_size (table_size_reg),
        .push       (push)
    );

    brsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (q_pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    brsp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head             (head),
        .empty            (q_empty),
        .pop              (q_pop),
        .load_base        (load_base_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_target_address (m_target_address),
        .m_fixup_width    (m_fixup_width),
        .m_status         (m_status)
    );

    // A command is only produced by an accepted halfword
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> in_fire)
        else $error("queue push without an accepted halfword");

    // After an invalid block nothing more is queued
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid && push.cmd.status |=> !push.valid)
        else $error("command queued after parse stop");

    // Error results carry a zero address and width
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> (m_target_address == '0) && !m_fixup_width)
        else $error("error request with nonzero fields");

endmodule

`default_nettype wire
